FILE: rtl/shk_pkg.sv
// Shared constants, state types and interface structs of the stream hasher.
package shk_pkg;

    localparam int unsigned LaneCount = 4;
    localparam int unsigned PendDepth = 3;

    localparam logic [63:0] SEED_A  = 64'h16F1_1FE8_9B0D_677C;
    localparam logic [63:0] SEED_B  = 64'hB480_A793_D8E6_C86C;
    localparam logic [63:0] SEED_C  = 64'h6FE2_E5AA_F078_EBC9;
    localparam logic [63:0] SEED_D  = 64'h14F9_94A4_C525_9381;
    localparam logic [63:0] MIX_MUL = 64'h6EED_0E9D_A4D9_4A4F;

    localparam logic [3:0] FULL_WORD_BYTES = 4'd8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GROUP,
        ST_TAIL,
        ST_PART,
        ST_FINAL
    } ctl_state_t;

    typedef enum logic [2:0] {
        MX_IDLE,
        MX_P0,
        MX_P1,
        MX_P2,
        MX_FOLD
    } mix_state_t;

    typedef struct packed {
        logic        start;
        logic [63:0] operand;
    } mix_req_t;

    typedef struct packed {
        logic        idle;
        logic        done;
        logic [63:0] result;
    } mix_rsp_t;

endpackage

FILE: rtl/seahash_stream_hasher_unit.sv
// Top level of the stream hasher: word intake, lane sequencer and digest output register.
//
//   Channel  Direction  Ports                                           Transaction
//   s_       in         s_data_word, s_byte_count, s_last_word          one message word
//   m_       out        m_digest                                        one 64-bit digest
//
// One diffusion runs on the shared unit (three 32x32 partial products per multiply).
// A word that only enters the buffer needs no diffusion; the fourth word of a group adds four
// diffusions. A last word adds one diffusion per buffered word, one for a partial word and one
// for the digest. Reset is synchronous and returns the lanes to their seeds.
// The next message may start while a digest still waits; the digest diffusion of that message
// waits until the output register is free.
module seahash_stream_hasher_unit import shk_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_data_word,
    input  logic [3:0]  s_byte_count,
    input  logic        s_last_word,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_digest
);

    ctl_state_t  state_reg, state_next;
    logic [63:0] lane_reg [LaneCount];
    logic [63:0] lane_next [LaneCount];
    logic [63:0] pend_reg [PendDepth];
    logic [1:0]  pend_cnt_reg, pend_cnt_next;
    logic [63:0] total_reg, total_next;
    logic [63:0] word_reg, word_next;
    logic        last_reg, last_next;
    logic        part_reg, part_next;
    logic [1:0]  idx_reg, idx_next;
    logic        issued_reg, issued_next;
    logic        m_valid_reg, m_valid_next;
    logic [63:0] digest_reg, digest_next;

    logic        in_fire;
    logic [3:0]  cnt_clamp;
    logic [63:0] word_masked;
    logic        push;
    logic        pend_wr;
    logic        need_mix;
    logic [63:0] grp_word;
    mix_req_t    mreq;
    mix_rsp_t    mrsp;

    shk_mix u_mix (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mreq),
        .rsp     (mrsp)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign in_fire  = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_digest = digest_reg;

    always_comb begin
        cnt_clamp = (s_byte_count > FULL_WORD_BYTES) ? FULL_WORD_BYTES : s_byte_count;
        for (int i = 0; i < 8; i++) begin
            word_masked[8*i +: 8] = (4'(i) < cnt_clamp) ? s_data_word[8*i +: 8] : 8'd0;
        end
        push     = (cnt_clamp != 4'd0) && (!s_last_word || cnt_clamp == FULL_WORD_BYTES);
        grp_word = (idx_reg == 2'd3) ? word_reg : pend_reg[idx_reg];

        need_mix = 1'b0;
        case (state_reg)
            ST_GROUP: need_mix = 1'b1;
            ST_TAIL:  need_mix = (idx_reg < pend_cnt_reg);
            ST_PART:  need_mix = part_reg;
            ST_FINAL: need_mix = !m_valid_reg || m_ready;
            default:  need_mix = 1'b0;
        endcase

        mreq.start   = need_mix && !issued_reg;
        mreq.operand = lane_reg[0] ^ word_reg;
        case (state_reg)
            ST_GROUP: mreq.operand = lane_reg[idx_reg] ^ grp_word;
            ST_TAIL:  mreq.operand = lane_reg[0] ^ pend_reg[idx_reg];
            ST_FINAL: mreq.operand = lane_reg[0] ^ lane_reg[1] ^ lane_reg[2] ^ lane_reg[3]
                                     ^ total_reg;
            default:  mreq.operand = lane_reg[0] ^ word_reg;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    if (push && pend_cnt_reg == 2'd3) begin
                        state_next = ST_GROUP;
                    end else if (s_last_word) begin
                        state_next = ST_TAIL;
                    end
                end
            end
            ST_GROUP: begin
                if (mrsp.done && idx_reg == 2'd3) begin
                    state_next = last_reg ? ST_TAIL : ST_IDLE;
                end
            end
            ST_TAIL: begin
                if (!need_mix) begin
                    state_next = ST_PART;
                end
            end
            ST_PART: begin
                if (!part_reg || mrsp.done) begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL: begin
                if (mrsp.done) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        for (int i = 0; i < LaneCount; i++) begin
            lane_next[i] = lane_reg[i];
        end
        pend_cnt_next = pend_cnt_reg;
        total_next    = total_reg;
        word_next     = word_reg;
        last_next     = last_reg;
        part_next     = part_reg;
        idx_next      = idx_reg;
        issued_next   = issued_reg;
        digest_next   = digest_reg;
        pend_wr       = 1'b0;
        m_valid_next  = m_valid_reg && !m_ready;

        if (mreq.start) begin
            issued_next = 1'b1;
        end
        if (mrsp.done) begin
            issued_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    word_next  = word_masked;
                    last_next  = s_last_word;
                    part_next  = s_last_word && (cnt_clamp != 4'd0)
                                 && (cnt_clamp != FULL_WORD_BYTES);
                    total_next = total_reg + {60'd0, cnt_clamp};
                    idx_next   = 2'd0;
                    if (push) begin
                        if (pend_cnt_reg == 2'd3) begin
                            pend_cnt_next = 2'd0;
                        end else begin
                            pend_wr       = 1'b1;
                            pend_cnt_next = pend_cnt_reg + 2'd1;
                        end
                    end
                end
            end
            ST_GROUP: begin
                if (mrsp.done) begin
                    lane_next[idx_reg] = mrsp.result;
                    idx_next           = idx_reg + 2'd1;
                end
            end
            ST_TAIL: begin
                if (!need_mix) begin
                    idx_next = 2'd0;
                end else if (mrsp.done) begin
                    lane_next[0] = lane_reg[1];
                    lane_next[1] = lane_reg[2];
                    lane_next[2] = lane_reg[3];
                    lane_next[3] = mrsp.result;
                    idx_next     = idx_reg + 2'd1;
                end
            end
            ST_PART: begin
                if (mrsp.done) begin
                    lane_next[0] = lane_reg[1];
                    lane_next[1] = lane_reg[2];
                    lane_next[2] = lane_reg[3];
                    lane_next[3] = mrsp.result;
                end
            end
            ST_FINAL: begin
                if (mrsp.done) begin
                    digest_next   = mrsp.result;
                    m_valid_next  = 1'b1;
                    lane_next[0]  = SEED_A;
                    lane_next[1]  = SEED_B;
                    lane_next[2]  = SEED_C;
                    lane_next[3]  = SEED_D;
                    pend_cnt_next = 2'd0;
                    total_next    = '0;
                end
            end
            default: idx_next = idx_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            lane_reg[0]  <= SEED_A;
            lane_reg[1]  <= SEED_B;
            lane_reg[2]  <= SEED_C;
            lane_reg[3]  <= SEED_D;
            pend_cnt_reg <= 2'd0;
            total_reg    <= '0;
            last_reg     <= 1'b0;
            part_reg     <= 1'b0;
            idx_reg      <= 2'd0;
            issued_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            lane_reg     <= lane_next;
            pend_cnt_reg <= pend_cnt_next;
            total_reg    <= total_next;
            last_reg     <= last_next;
            part_reg     <= part_next;
            idx_reg      <= idx_next;
            issued_reg   <= issued_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg   <= word_next;
        digest_reg <= digest_next;
        if (pend_wr) begin
            pend_reg[pend_cnt_reg] <= word_masked;
        end
    end

    a_start_when_idle : assert property (@(posedge aclk) disable iff (!aresetn)
        mreq.start |-> mrsp.idle)
        else $error("diffusion started while the unit was busy");

    a_ready_unit_free : assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> mrsp.idle && !issued_reg)
        else $error("input taken while a diffusion was in flight");

    a_done_in_work : assert property (@(posedge aclk) disable iff (!aresetn)
        mrsp.done |-> state_reg != ST_IDLE && issued_reg)
        else $error("diffusion result arrived with no request outstanding");

    a_digest_clears : assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> total_reg == '0 && pend_cnt_reg == 2'd0 && lane_reg[0] == SEED_A)
        else $error("state not returned to seeds after a digest");

endmodule

FILE: rtl/shk_mix.sv
// Iterative diffusion unit: multiply, data-dependent xorshift, multiply on one 32x32 multiplier.
module shk_mix import shk_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  mix_req_t req,
    output mix_rsp_t rsp
);

    mix_state_t  state_reg, state_next;
    logic        pass_reg, pass_next;
    logic [63:0] x_reg, x_next;
    logic [63:0] acc_reg, acc_next;
    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;
    logic [31:0] shift_hi;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            MX_IDLE: begin
                if (req.start) begin
                    state_next = MX_P0;
                end
            end
            MX_P0:   state_next = MX_P1;
            MX_P1:   state_next = MX_P2;
            MX_P2:   state_next = MX_FOLD;
            MX_FOLD: state_next = pass_reg ? MX_IDLE : MX_P0;
            default: state_next = MX_IDLE;
        endcase
    end

    always_comb begin
        mul_a = x_reg[31:0];
        mul_b = MIX_MUL[31:0];
        case (state_reg)
            MX_P1: begin
                mul_a = x_reg[63:32];
                mul_b = MIX_MUL[31:0];
            end
            MX_P2: begin
                mul_a = x_reg[31:0];
                mul_b = MIX_MUL[63:32];
            end
            default: begin
                mul_a = x_reg[31:0];
                mul_b = MIX_MUL[31:0];
            end
        endcase
        prod     = {32'd0, mul_a} * {32'd0, mul_b};
        shift_hi = acc_reg[63:32] >> acc_reg[63:60];

        x_next    = x_reg;
        acc_next  = acc_reg;
        pass_next = pass_reg;
        case (state_reg)
            MX_IDLE: begin
                if (req.start) begin
                    x_next    = req.operand;
                    pass_next = 1'b0;
                end
            end
            MX_P0: acc_next = prod;
            MX_P1, MX_P2: acc_next = {acc_reg[63:32] + prod[31:0], acc_reg[31:0]};
            MX_FOLD: begin
                if (!pass_reg) begin
                    x_next    = acc_reg ^ {32'd0, shift_hi};
                    pass_next = 1'b1;
                end
            end
            default: acc_next = acc_reg;
        endcase

        rsp.idle   = (state_reg == MX_IDLE);
        rsp.done   = (state_reg == MX_FOLD) && pass_reg;
        rsp.result = acc_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= MX_IDLE;
            pass_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg   <= x_next;
        acc_reg <= acc_next;
    end

    a_done_after_p2 : assert property (@(posedge aclk) disable iff (!aresetn)
        rsp.done |-> $past(state_reg) == MX_P2)
        else $error("diffusion finished without a full multiply pass");

    a_fold_exits : assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == MX_FOLD |=> state_reg == MX_IDLE || state_reg == MX_P0)
        else $error("fold step left to a wrong step");

    a_pass_from_fold : assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(pass_reg) |-> $past(state_reg) == MX_FOLD)
        else $error("second pass began outside the fold step");

endmodule
